// ===== hw/rtl/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants of the receive packet ring buffer
// Field widths, mode and status codes, and the command word that travels
// from the front end to the back end.
// ----------------------------------------------------------------------------
package rpf_pkg;

    // Default ring depth in bytes.
    localparam int DEPTH_DEF = 1024;

    // Field widths.
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int SRC_W    = 16;
    localparam int PLEN_W   = 7;
    localparam int FREE_W   = 10;
    localparam int LEN_W    = 16;
    // Width of a length plus header count.
    localparam int LEN6_W   = 17;

    // Framing constants.
    localparam int HDR_BYTES  = 6;
    localparam int TYPE_BYTES = 2;
    localparam int CAP_MIN    = 2;
    localparam int CAP_MAX    = 64;
    localparam logic [PLEN_W-1:0] MAXP_RESET = PLEN_W'(64);

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FETCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PKT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOPKT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FLUSHED = 3'd4;

    // Decoded operation held in the command queue.
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_FETCH,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

endpackage

// ===== hw/rtl/rpf_ram.sv =====
// ----------------------------------------------------------------------------
// rpf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. The read data holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module rpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/rpf_front.sv =====
// ----------------------------------------------------------------------------
// rpf_front: input decode and command queue
// Accepts input words, turns the mode into an operation, drops the unused
// mode, and holds up to two commands for the back end.
// ----------------------------------------------------------------------------
module rpf_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rpf_pkg::MODE_W-1:0] s_mode,
    input  logic [rpf_pkg::BYTE_W-1:0] s_data,
    output logic                       cmd_valid,
    output rpf_pkg::cmd_t              cmd,
    input  logic                       cmd_pop
);
    import rpf_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    cmd_t              ent_reg [QDEPTH];
    logic              rd_sel_reg, rd_sel_next;
    logic              wr_sel_reg, wr_sel_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              enq;
    cmd_t              dec_cmd;
    logic              dec_ok;

    // Classify the incoming word; the unused mode gives no command.
    always_comb begin
        dec_cmd.data = s_data;
        dec_cmd.op   = OP_PUSH;
        dec_ok       = 1'b1;
        case (s_mode)
            MODE_PUSH:  dec_cmd.op = OP_PUSH;
            MODE_FETCH: dec_cmd.op = OP_FETCH;
            MODE_FLUSH: dec_cmd.op = OP_FLUSH;
            default:    dec_ok     = 1'b0;
        endcase
    end

    assign s_tready  = (fill_reg != QCNT_W'(QDEPTH));
    assign enq       = s_tvalid && s_tready && dec_ok;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = ent_reg[rd_sel_reg];

    // Queue pointer and fill bookkeeping.
    always_comb begin
        rd_sel_next = cmd_pop ? ~rd_sel_reg : rd_sel_reg;
        wr_sel_next = enq ? ~wr_sel_reg : wr_sel_reg;
        fill_next   = fill_reg + QCNT_W'(enq) - QCNT_W'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_sel_reg <= 1'b0;
            wr_sel_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            rd_sel_reg <= rd_sel_next;
            wr_sel_reg <= wr_sel_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (enq) begin
            ent_reg[wr_sel_reg] <= dec_cmd;
        end
    end

endmodule

// ===== hw/rtl/rpf_back.sv =====
// ----------------------------------------------------------------------------
// rpf_back: ring buffer engine
// Executes push, fetch and flush commands against the byte ring and drives
// the result register. A fetch reads the packet a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module rpf_back #(
    parameter int DEPTH = rpf_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [rpf_pkg::PLEN_W-1:0]   cfg_data,
    input  logic                         cmd_valid,
    input  rpf_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rpf_pkg::STATUS_W-1:0] m_status,
    output logic [rpf_pkg::BYTE_W-1:0]   m_byte,
    output logic [rpf_pkg::SRC_W-1:0]    m_src,
    output logic [rpf_pkg::PLEN_W-1:0]   m_plen,
    output logic                         m_last,
    output logic [rpf_pkg::FREE_W-1:0]   m_free
);
    import rpf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN0,
        S_LEN1,
        S_SRC0,
        S_SRC1,
        S_PAY
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   cnt_reg, cnt_next;
    logic [PTR_W-1:0]   raddr_reg, raddr_next;
    logic [PTR_W-1:0]   end_reg, end_next;
    logic [BYTE_W-1:0]  len_lo_reg, len_lo_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [LEN6_W-1:0]  remain_reg, remain_next;
    logic [PLEN_W-1:0]  give_reg, give_next;
    logic [PLEN_W-1:0]  idx_reg, idx_next;
    logic [PLEN_W-1:0]  maxp_reg, maxp_next;

    logic                mv_reg, mv_next;
    logic [STATUS_W-1:0] ms_reg, ms_next;
    logic [BYTE_W-1:0]   mb_reg, mb_next;
    logic [SRC_W-1:0]    msrc_reg, msrc_next;
    logic [PLEN_W-1:0]   mp_reg, mp_next;
    logic                ml_reg, ml_next;
    logic [FREE_W-1:0]   mf_reg, mf_next;

    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              out_free;
    logic [LEN_W-1:0]  len_val;
    logic [LEN6_W-1:0] len6, total;
    logic [PTR_W:0]    end_sum;
    logic [PLEN_W-1:0] cap;
    logic [PTR_W-1:0]  cnt_dec;

    // Next ring position with wrap at the depth.
    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Free bytes for a given fill level, cut to the result field.
    function automatic logic [FREE_W-1:0] free_of(input logic [PTR_W-1:0] c);
        logic [LEN6_W-1:0] f;
        f = LEN6_W'(DEPTH - 1) - LEN6_W'(c);
        return f[FREE_W-1:0];
    endfunction

    rpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (cmd.data),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Header arithmetic used once the second length byte is back.
    always_comb begin
        len_val = {ram_rdata, len_lo_reg};
        len6    = LEN6_W'(len_val) + LEN6_W'(HDR_BYTES);
        total   = LEN6_W'(len_val) + LEN6_W'(TYPE_BYTES);
        end_sum = (PTR_W + 1)'(rp_reg) + (PTR_W + 1)'(len6[PTR_W-1:0]);
        if (maxp_reg < PLEN_W'(CAP_MIN)) begin
            cap = PLEN_W'(CAP_MIN);
        end else if (maxp_reg > PLEN_W'(CAP_MAX)) begin
            cap = PLEN_W'(CAP_MAX);
        end else begin
            cap = maxp_reg;
        end
        cnt_dec = cnt_reg - PTR_W'(1);
    end

    assign out_free = !mv_reg || m_ready;

    // Command sequencer.
    always_comb begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        cnt_next    = cnt_reg;
        raddr_next  = raddr_reg;
        end_next    = end_reg;
        len_lo_next = len_lo_reg;
        src_next    = src_reg;
        remain_next = remain_reg;
        give_next   = give_reg;
        idx_next    = idx_reg;
        maxp_next   = cfg_valid ? cfg_data : maxp_reg;
        mv_next     = mv_reg && !m_ready;
        ms_next     = ms_reg;
        mb_next     = mb_reg;
        msrc_next   = msrc_reg;
        mp_next     = mp_reg;
        ml_next     = ml_reg;
        mf_next     = mf_reg;
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = raddr_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop   = 1'b1;
                    mb_next   = '0;
                    msrc_next = '0;
                    mp_next   = '0;
                    ml_next   = 1'b1;
                    case (cmd.op)
                        OP_PUSH: begin
                            mv_next = 1'b1;
                            if (cnt_reg == PTR_W'(DEPTH - 1)) begin
                                ms_next = ST_DROPPED;
                                mf_next = free_of(cnt_reg);
                            end else begin
                                ram_we   = 1'b1;
                                wp_next  = wrap_inc(wp_reg);
                                cnt_next = cnt_reg + PTR_W'(1);
                                ms_next  = ST_PUSHED;
                                mf_next  = free_of(cnt_reg + PTR_W'(1));
                            end
                        end
                        OP_FLUSH: begin
                            mv_next  = 1'b1;
                            wp_next  = '0;
                            rp_next  = '0;
                            cnt_next = '0;
                            ms_next  = ST_FLUSHED;
                            mf_next  = free_of('0);
                        end
                        OP_FETCH: begin
                            if (cnt_reg < PTR_W'(HDR_BYTES)) begin
                                mv_next = 1'b1;
                                ms_next = ST_NOPKT;
                                mf_next = free_of(cnt_reg);
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = rp_reg;
                                raddr_next = wrap_inc(rp_reg);
                                state_next = S_LEN0;
                            end
                        end
                        default: begin
                            mv_next = mv_reg && !m_ready;
                        end
                    endcase
                end
            end

            // Low length byte is back; ask for the high one.
            S_LEN0: begin
                len_lo_next = ram_rdata;
                ram_re      = 1'b1;
                raddr_next  = wrap_inc(raddr_reg);
                state_next  = S_LEN1;
            end

            // Decide whether the whole packet is buffered.
            S_LEN1: begin
                if (LEN6_W'(cnt_reg) < len6) begin
                    if (out_free) begin
                        mv_next    = 1'b1;
                        ms_next    = ST_NOPKT;
                        mb_next    = '0;
                        msrc_next  = '0;
                        mp_next    = '0;
                        ml_next    = 1'b1;
                        mf_next    = free_of(cnt_reg);
                        state_next = S_IDLE;
                    end
                end else begin
                    end_next    = (end_sum >= (PTR_W + 1)'(DEPTH))
                                ? PTR_W'(end_sum - (PTR_W + 1)'(DEPTH))
                                : end_sum[PTR_W-1:0];
                    remain_next = total;
                    give_next   = (total > LEN6_W'(cap)) ? cap : total[PLEN_W-1:0];
                    cnt_next    = cnt_reg - PTR_W'(TYPE_BYTES + TYPE_BYTES);
                    ram_re      = 1'b1;
                    raddr_next  = wrap_inc(raddr_reg);
                    state_next  = S_SRC0;
                end
            end

            S_SRC0: begin
                src_next[BYTE_W-1:0] = ram_rdata;
                ram_re               = 1'b1;
                raddr_next           = wrap_inc(raddr_reg);
                state_next           = S_SRC1;
            end

            // Source complete; ask for the first payload byte.
            S_SRC1: begin
                src_next[SRC_W-1:BYTE_W] = ram_rdata;
                ram_re                   = 1'b1;
                raddr_next               = wrap_inc(raddr_reg);
                idx_next                 = '0;
                state_next               = S_PAY;
            end

            // One payload byte per cycle unless the result is stalled; the last one skips the tail.
            S_PAY: begin
                if (out_free) begin
                    mv_next   = 1'b1;
                    ms_next   = ST_PKT;
                    mb_next   = ram_rdata;
                    msrc_next = src_reg;
                    mp_next   = give_reg;
                    if (idx_reg + PLEN_W'(1) == give_reg) begin
                        ml_next    = 1'b1;
                        cnt_next   = cnt_reg - PTR_W'(remain_reg);
                        mf_next    = free_of(cnt_reg - PTR_W'(remain_reg));
                        rp_next    = end_reg;
                        state_next = S_IDLE;
                    end else begin
                        ml_next     = 1'b0;
                        cnt_next    = cnt_dec;
                        mf_next     = free_of(cnt_dec);
                        remain_next = remain_reg - LEN6_W'(1);
                        idx_next    = idx_reg + PLEN_W'(1);
                        ram_re      = 1'b1;
                        raddr_next  = wrap_inc(raddr_reg);
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, ring pointers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            maxp_reg  <= MAXP_RESET;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
            maxp_reg  <= maxp_next;
            mv_reg    <= mv_next;
        end
        raddr_reg  <= raddr_next;
        end_reg    <= end_next;
        len_lo_reg <= len_lo_next;
        src_reg    <= src_next;
        remain_reg <= remain_next;
        give_reg   <= give_next;
        idx_reg    <= idx_next;
        ms_reg     <= ms_next;
        mb_reg     <= mb_next;
        msrc_reg   <= msrc_next;
        mp_reg     <= mp_next;
        ml_reg     <= ml_next;
        mf_reg     <= mf_next;
    end

    assign m_valid  = mv_reg;
    assign m_status = ms_reg;
    assign m_byte   = mb_reg;
    assign m_src    = msrc_reg;
    assign m_plen   = mp_reg;
    assign m_last   = ml_reg;
    assign m_free   = mf_reg;

endmodule

// ===== hw/rtl/rx_packet_ring_fifo_top.sv =====
// ----------------------------------------------------------------------------
// rx_packet_ring_fifo_top: receive ring buffer for length-prefixed packets
//
//   Channel  Direction  Word contents
//   s_*      in         tuser = mode, tdata = received byte
//   m_*      out        tuser = status, tlast = last, tdata = byte/src/len/free
//   cfg_*    in         cfg_data = largest payload handed out per fetch
//
// A push, a flush or a fetch on fewer than six buffered bytes gives one result
// word from the idle state; a fetch that finds the packet incomplete answers
// once both length bytes are read. A fetch of a complete packet checks the
// length, reads the source and then the payload bytes one by one through the
// single read port of the byte RAM; the discarded tail is skipped at once.
// Reset clears the pointers and fill level; the byte RAM is not cleared.
// A stalled m_tready holds the engine at its next result word; the two-word
// command queue absorbs up to two more input words before s_tready drops.
// ----------------------------------------------------------------------------
module rx_packet_ring_fifo_top #(
    parameter int DEPTH = rpf_pkg::DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [7:0] data_byte
    input  logic [7:0]                 s_tdata,
    // [1:0] mode
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] out_byte, [23:8] source_node, [30:24] payload_len,
    // [40:31] free_space, [47:41] zero
    output logic [47:0]                m_tdata,
    // [2:0] status
    output logic [2:0]                 m_tuser,
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rpf_pkg::PLEN_W-1:0] cfg_data
);
    import rpf_pkg::*;

    logic                cmd_valid;
    cmd_t                cmd;
    logic                cmd_pop;
    logic [BYTE_W-1:0]   r_byte;
    logic [SRC_W-1:0]    r_src;
    logic [PLEN_W-1:0]   r_plen;
    logic [FREE_W-1:0]   r_free;

    // The register is always writable.
    assign cfg_ready = 1'b1;

    rpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_mode    (s_tuser),
        .s_data    (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    rpf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_status  (m_tuser),
        .m_byte    (r_byte),
        .m_src     (r_src),
        .m_plen    (r_plen),
        .m_last    (m_tlast),
        .m_free    (r_free)
    );

    // Pack the result fields from the lowest bit up.
    assign m_tdata = {7'b0, r_free, r_plen, r_src, r_byte};

endmodule
